// ===== rtl/per_routine_serializing_slot_table_macros.svh =====
// Assertion macros used by the slot table sequencer.
`ifndef PER_ROUTINE_SERIALIZING_SLOT_TABLE_MACROS_SVH
`define PER_ROUTINE_SERIALIZING_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot table assertion failed");

// Next-cycle implication, checked outside reset.
`define PSST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot table assertion failed");

`endif

// ===== rtl/psst_pkg.sv =====
// Shared types and constants for the per-routine serializing slot table.
package psst_pkg;

  localparam int SLOTS        = 8;
  localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROUTINE_BITS = 16;
  localparam int ARG_BITS     = 32;
  localparam int TID_BITS     = 32;
  localparam int DONE_BITS    = 3;
  localparam int STATUS_BITS  = 2;

  // Request opcodes
  localparam logic OP_CREATE   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_ACTIVE = 2'd2;

  typedef enum logic [1:0] {
    K_EMPTY   = 2'd0,
    K_ACTIVE  = 2'd1,
    K_WAITING = 2'd2
  } kind_t;

  // Write command into the slot store, with one enable per field
  typedef struct packed {
    logic                    kind_we;
    logic                    rtn_we;
    logic                    ref_we;
    logic                    arg_we;
    logic [IDX_W-1:0]        addr;
    kind_t                   kind;
    logic [ROUTINE_BITS-1:0] rtn;
    logic [IDX_W-1:0]        wait_ref;
    logic [ARG_BITS-1:0]     arg;
  } slot_wr_t;

  // Read data of one slot
  typedef struct packed {
    kind_t                   kind;
    logic [ROUTINE_BITS-1:0] rtn;
    logic [IDX_W-1:0]        wait_ref;
    logic [ARG_BITS-1:0]     arg;
  } slot_rd_t;

endpackage

// ===== rtl/psst_if.sv =====
// Request and result channel interfaces of the slot table.
interface psst_req_if;
  import psst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [ROUTINE_BITS-1:0] routine_id;
  logic [ARG_BITS-1:0]     job_arg;
  logic [DONE_BITS-1:0]    done_slot;

  modport source (output valid, opcode, routine_id, job_arg, done_slot, input ready);
  modport sink (input valid, opcode, routine_id, job_arg, done_slot, output ready);
endinterface

interface psst_rsp_if;
  import psst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [TID_BITS-1:0]     thread_id;
  logic [DONE_BITS-1:0]    slot_index;
  logic                    became_active;
  logic [ROUTINE_BITS-1:0] active_routine;
  logic [ARG_BITS-1:0]     active_arg;

  modport source (output valid, status, thread_id, slot_index, became_active,
                  active_routine, active_arg, input ready);
  modport sink (input valid, status, thread_id, slot_index, became_active,
                active_routine, active_arg, output ready);
endinterface

// ===== rtl/psst_slot_store.sv =====
// Slot store: kind flags with reset, job payload without reset, one read port.
module psst_slot_store
  import psst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_rd_t         rd
);

  kind_t                   kind     [SLOTS];
  logic [ROUTINE_BITS-1:0] rtn      [SLOTS];
  logic [IDX_W-1:0]        wait_ref [SLOTS];
  logic [ARG_BITS-1:0]     arg      [SLOTS];

  // Clear all kinds to empty on reset, else take the write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        kind[i] <= K_EMPTY;
      end
    end else if (wr.kind_we) begin
      kind[wr.addr] <= wr.kind;
    end
  end

  // Write the payload fields
  always_ff @(posedge clk) begin
    if (wr.rtn_we) begin
      rtn[wr.addr] <= wr.rtn;
    end
    if (wr.ref_we) begin
      wait_ref[wr.addr] <= wr.wait_ref;
    end
    if (wr.arg_we) begin
      arg[wr.addr] <= wr.arg;
    end
  end

  // Read one slot
  always_comb begin
    rd.kind     = kind[rd_addr];
    rd.rtn      = rtn[rd_addr];
    rd.wait_ref = wait_ref[rd_addr];
    rd.arg      = arg[rd_addr];
  end

endmodule

// ===== rtl/psst_seq.sv =====
// Sequencer: walks the slots one per cycle and applies create and complete.
`include "per_routine_serializing_slot_table_macros.svh"
module psst_seq
  import psst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  psst_req_if.sink         req,
  psst_rsp_if.source       rsp,
  output slot_wr_t         wr,
  output logic [IDX_W-1:0] rd_addr,
  input  slot_rd_t         rd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN_C  = 6'b000010,
    S_WRITE_C = 6'b000100,
    S_CHECK   = 6'b001000,
    S_SCAN_P  = 6'b010000,
    S_FREE    = 6'b100000
  } state_t;

  state_t                  state;
  logic                    fin;        // result ready to hand to the output stage
  logic [IDX_W-1:0]        idx;
  logic [ROUTINE_BITS-1:0] in_rtn;
  logic [ARG_BITS-1:0]     in_arg;
  logic [DONE_BITS-1:0]    in_done;
  logic                    have_empty;
  logic [IDX_W-1:0]        empty_at;
  logic                    have_active;
  logic [IDX_W-1:0]        active_at;
  logic                    promoted;
  logic [IDX_W-1:0]        new_at;
  logic [ROUTINE_BITS-1:0] done_rtn;
  logic [TID_BITS-1:0]     id_ctr;
  logic [TID_BITS-1:0]     id_ctr_next;

  logic [STATUS_BITS-1:0]  r_status;
  logic [TID_BITS-1:0]     r_tid;
  logic [IDX_W-1:0]        r_slot;
  logic                    r_act;
  logic [ROUTINE_BITS-1:0] r_rtn;
  logic [ARG_BITS-1:0]     r_arg;

  logic                    accept;
  logic                    last;
  logic                    out_free;
  logic [IDX_W-1:0]        done_idx;
  logic                    done_in_range;
  logic                    rtn_hit;
  logic                    ref_hit;

  assign accept        = req.valid && req.ready;
  assign last          = (idx == IDX_W'(SLOTS - 1));
  assign out_free      = !rsp.valid || rsp.ready;
  assign done_idx      = IDX_W'(in_done);
  assign done_in_range = (int'(in_done) < SLOTS);
  assign req.ready     = (state == S_IDLE) && !fin;

  // Shared compare unit on the slot being read
  assign rtn_hit = (rd.kind == K_ACTIVE) && (rd.rtn == in_rtn);
  assign ref_hit = (rd.kind == K_WAITING) && (rd.wait_ref == done_idx);

  // Skip zero when the id counter wraps
  always_comb begin
    id_ctr_next = id_ctr + TID_BITS'(1);
    if (id_ctr_next == '0) begin
      id_ctr_next = TID_BITS'(1);
    end
  end

  // Address the store: the completed slot during check and free, else the scan
  assign rd_addr = (state == S_CHECK || state == S_FREE) ? done_idx : idx;

  // Drive store writes
  always_comb begin
    wr          = '0;
    wr.kind     = K_EMPTY;
    wr.addr     = idx;
    wr.rtn      = in_rtn;
    wr.arg      = in_arg;
    case (state)
      S_WRITE_C: begin
        wr.addr = empty_at;
        if (have_empty) begin
          wr.kind_we  = 1'b1;
          wr.rtn_we   = 1'b1;
          wr.ref_we   = 1'b1;
          wr.arg_we   = 1'b1;
          wr.kind     = have_active ? K_WAITING : K_ACTIVE;
          wr.wait_ref = have_active ? active_at : '0;
        end
      end
      S_SCAN_P: begin
        if (ref_hit) begin
          if (!promoted) begin
            wr.kind_we  = 1'b1;
            wr.rtn_we   = 1'b1;
            wr.ref_we   = 1'b1;
            wr.kind     = K_ACTIVE;
            wr.rtn      = done_rtn;
            wr.wait_ref = '0;
          end else begin
            wr.ref_we   = 1'b1;
            wr.wait_ref = new_at;
          end
        end
      end
      S_FREE: begin
        wr.kind_we = 1'b1;
        wr.addr    = done_idx;
        wr.kind    = K_EMPTY;
      end
      default: begin
      end
    endcase
  end

  // Control: sequence, scan flags, id counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fin         <= 1'b0;
      idx         <= '0;
      have_empty  <= 1'b0;
      have_active <= 1'b0;
      promoted    <= 1'b0;
      id_ctr      <= TID_BITS'(1);
      rsp.valid   <= 1'b0;
    end else begin
      // Drop the output once taken, load it when a result is finished
      if (fin && out_free) begin
        rsp.valid <= 1'b1;
        fin       <= 1'b0;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            idx         <= '0;
            have_empty  <= 1'b0;
            have_active <= 1'b0;
            promoted    <= 1'b0;
            state       <= (req.opcode == OP_CREATE) ? S_SCAN_C : S_CHECK;
          end
        end
        S_SCAN_C: begin
          if (!have_empty && rd.kind == K_EMPTY) begin
            have_empty <= 1'b1;
          end
          if (!have_active && rtn_hit) begin
            have_active <= 1'b1;
          end
          idx <= idx + IDX_W'(1);
          if (last) begin
            state <= S_WRITE_C;
          end
        end
        S_WRITE_C: begin
          if (have_empty) begin
            id_ctr <= id_ctr_next;
          end
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        S_CHECK: begin
          if (!done_in_range || rd.kind != K_ACTIVE) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= '0;
            state <= S_SCAN_P;
          end
        end
        S_SCAN_P: begin
          if (ref_hit) begin
            promoted <= 1'b1;
          end
          idx <= idx + IDX_W'(1);
          if (last) begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: latched request, scan positions, result fields
  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      rsp.status         <= r_status;
      rsp.thread_id      <= r_tid;
      rsp.slot_index     <= DONE_BITS'(r_slot);
      rsp.became_active  <= r_act;
      rsp.active_routine <= r_rtn;
      rsp.active_arg     <= r_arg;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          in_rtn   <= req.routine_id;
          in_arg   <= req.job_arg;
          in_done  <= req.done_slot;
          r_status <= ST_OK;
          r_tid    <= '0;
          r_slot   <= '0;
          r_act    <= 1'b0;
          r_rtn    <= '0;
          r_arg    <= '0;
        end
      end
      S_SCAN_C: begin
        if (!have_empty && rd.kind == K_EMPTY) begin
          empty_at <= idx;
        end
        if (!have_active && rtn_hit) begin
          active_at <= idx;
        end
      end
      S_WRITE_C: begin
        if (!have_empty) begin
          r_status <= ST_FULL;
        end else begin
          r_tid  <= id_ctr;
          r_slot <= empty_at;
          if (!have_active) begin
            r_act <= 1'b1;
            r_rtn <= in_rtn;
            r_arg <= in_arg;
          end
        end
      end
      S_CHECK: begin
        done_rtn <= rd.rtn;
        if (!done_in_range || rd.kind != K_ACTIVE) begin
          r_status <= ST_NOT_ACTIVE;
        end
      end
      S_SCAN_P: begin
        if (ref_hit && !promoted) begin
          new_at <= idx;
          r_slot <= idx;
          r_act  <= 1'b1;
          r_rtn  <= done_rtn;
          r_arg  <= rd.arg;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `PSST_ASSERT_NXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `PSST_ASSERT_NOW(a_write_in_work_state, wr.kind_we || wr.ref_we,
                   state == S_WRITE_C || state == S_SCAN_P || state == S_FREE)
  `PSST_ASSERT_NOW(a_id_nonzero, 1'b1, id_ctr != '0)
  `PSST_ASSERT_NOW(a_error_clean, rsp.valid && rsp.status != ST_OK,
                   rsp.thread_id == '0 && !rsp.became_active)

endmodule

// ===== rtl/per_routine_serializing_slot_table.sv =====
// Per-routine serializing slot table: sequencer plus slot store.
// A create scans every slot, then writes; a complete checks the done slot, then scans
// and frees it, or returns straight after the check if that slot is not active.
// The sequencer scans the store one slot a cycle; an item is accepted only once the previous one is through.
// A new item is accepted while the previous result still waits on the output.
// Reset (rst, synchronous) empties every slot and sets the next thread id to one.
module per_routine_serializing_slot_table
  import psst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  psst_req_if.sink   req,
  psst_rsp_if.source rsp
);

  slot_wr_t         wr;
  slot_rd_t         rd;
  logic [IDX_W-1:0] rd_addr;

  psst_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  psst_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

endmodule

// ===== bench/per_routine_serializing_slot_table_test.sv =====
// Self-checking testbench for the per-routine serializing slot table.
`timescale 1ns / 100ps

module per_routine_serializing_slot_table_test;
  import psst_pkg::*;

  localparam int RANDOM_ITEMS = 1325;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic                    opcode;
    logic [ROUTINE_BITS-1:0] routine_id;
    logic [ARG_BITS-1:0]     job_arg;
    logic [DONE_BITS-1:0]    done_slot;
  } job_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [TID_BITS-1:0]     thread_id;
    logic [DONE_BITS-1:0]    slot_index;
    logic                    became_active;
    logic [ROUTINE_BITS-1:0] active_routine;
    logic [ARG_BITS-1:0]     active_arg;
  } job_result_t;

  // Shadow copy of the slot table plus the results it still owes
  class job_slot_tracker;
    kind_t                   kind[SLOTS];
    logic [ROUTINE_BITS-1:0] routine[SLOTS];
    logic [IDX_W-1:0]        wait_ref[SLOTS];
    logic [ARG_BITS-1:0]     arg[SLOTS];
    logic [TID_BITS-1:0]     next_tid;
    job_result_t             due_results[$];
    int                      errors;

    function new();
      foreach (kind[i]) kind[i] = K_EMPTY;
      next_tid = 1;
      errors   = 0;
    endfunction

    // Apply one accepted item to the shadow table and queue its result
    function void accept_request(job_req_t r);
      job_result_t res;
      int          free_at;
      int          active_at;
      int          new_at;
      res = '0;
      if (r.opcode == OP_CREATE) begin
        free_at   = -1;
        active_at = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (free_at < 0 && kind[i] == K_EMPTY) free_at = i;
          if (active_at < 0 && kind[i] == K_ACTIVE && routine[i] == r.routine_id)
            active_at = i;
        end
        if (free_at < 0) begin
          res.status = ST_FULL;
        end else begin
          res.status     = ST_OK;
          res.thread_id  = next_tid;
          res.slot_index = DONE_BITS'(free_at);
          next_tid++;
          if (next_tid == 0) next_tid = 1;
          routine[free_at] = r.routine_id;
          arg[free_at]     = r.job_arg;
          if (active_at >= 0) begin
            kind[free_at]     = K_WAITING;
            wait_ref[free_at] = IDX_W'(active_at);
          end else begin
            kind[free_at]        = K_ACTIVE;
            res.became_active    = 1'b1;
            res.active_routine   = r.routine_id;
            res.active_arg       = r.job_arg;
          end
        end
      end else if (kind[r.done_slot] != K_ACTIVE) begin
        res.status = ST_NOT_ACTIVE;
      end else begin
        // Promote the first waiter, re-point the rest to it
        new_at = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (kind[i] == K_WAITING && wait_ref[i] == r.done_slot) begin
            if (new_at < 0) begin
              new_at     = i;
              kind[i]    = K_ACTIVE;
              routine[i] = routine[r.done_slot];
            end else begin
              wait_ref[i] = IDX_W'(new_at);
            end
          end
        end
        kind[r.done_slot] = K_EMPTY;
        res.status = ST_OK;
        if (new_at >= 0) begin
          res.slot_index     = DONE_BITS'(new_at);
          res.became_active  = 1'b1;
          res.active_routine = routine[new_at];
          res.active_arg     = arg[new_at];
        end
      end
      due_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Match one result from the block against the oldest expectation
    function void check_result(job_result_t got);
      job_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("thread_id", want.thread_id, got.thread_id);
      compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      compare_field("became_active", 32'(want.became_active), 32'(got.became_active));
      compare_field("active_routine", 32'(want.active_routine), 32'(got.active_routine));
      compare_field("active_arg", want.active_arg, got.active_arg);
    endfunction

    function int occupied();
      int n;
      n = 0;
      foreach (kind[i]) if (kind[i] != K_EMPTY) n++;
      return n;
    endfunction

    function int random_active();
      int found[$];
      foreach (kind[i]) if (kind[i] == K_ACTIVE) found.push_back(i);
      if (found.size() == 0) return -1;
      return found[$urandom_range(found.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst;

  psst_req_if req ();
  psst_rsp_if rsp ();

  per_routine_serializing_slot_table dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  job_slot_tracker         sb;
  logic [ROUTINE_BITS-1:0] routine_pool[4];
  int                      burst_left;
  bit                      steady_feed;
  bit                      start_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Track accepted items on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        sb.accept_request({req.opcode, req.routine_id, req.job_arg, req.done_slot});
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.status, rsp.thread_id, rsp.slot_index, rsp.became_active,
                         rsp.active_routine, rsp.active_arg});
    end
  end

  // Result-side backpressure: rotating stall modes plus one long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    int recv_mode;
    int mode_cycles;
    hold_left   = 0;
    stall_left  = 0;
    recv_mode   = 0;
    mode_cycles = 0;
    rsp.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_cycles == 0) begin
        recv_mode   = $urandom_range(3);
        mode_cycles = $urandom_range(100, 300);
      end
      mode_cycles--;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (start_hold) begin
        start_hold = 1'b0;
        hold_left  = LONG_HOLD - 1;
        rsp.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= 1'($urandom_range(1));
          2: rsp.ready <= ($urandom_range(7) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rsp.ready <= 1'b0;
            end else if ($urandom_range(15) == 0) begin
              stall_left = $urandom_range(12);
              rsp.ready <= 1'b0;
            end else begin
              rsp.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin
    int idle;
    idle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic job_req_t make_req(logic op, logic [ROUTINE_BITS-1:0] rtn,
                                        logic [ARG_BITS-1:0] a, logic [DONE_BITS-1:0] slot);
    job_req_t r;
    r.opcode     = op;
    r.routine_id = rtn;
    r.job_arg    = a;
    r.done_slot  = slot;
    return r;
  endfunction

  // Few routine ids at a time, so that jobs queue behind each other
  function automatic void refresh_pool();
    foreach (routine_pool[i]) begin
      case ($urandom_range(5))
        0: routine_pool[i] = '0;
        1: routine_pool[i] = '1;
        default: routine_pool[i] = ROUTINE_BITS'($urandom);
      endcase
    end
  endfunction

  // Mostly creates on pooled routines and completes on active slots, some noise
  function automatic job_req_t random_request();
    job_req_t r;
    int       occ;
    int       create_pct;
    int       slot;
    r     = make_req(OP_CREATE, ROUTINE_BITS'($urandom), $urandom, DONE_BITS'($urandom));
    occ   = sb.occupied();
    create_pct = (occ <= 3) ? 70 : (occ <= 6) ? 50 : 35;
    if ($urandom_range(99) < create_pct) begin
      if ($urandom_range(9) != 0) r.routine_id = routine_pool[$urandom_range(3)];
    end else begin
      r.opcode = OP_COMPLETE;
      slot = sb.random_active();
      if (slot >= 0 && $urandom_range(9) != 0) r.done_slot = DONE_BITS'(slot);
    end
    return r;
  endfunction

  task automatic send_item(job_req_t r);
    @(negedge clk);
    req.valid      <= 1'b1;
    req.opcode     <= r.opcode;
    req.routine_id <= r.routine_id;
    req.job_arg    <= r.job_arg;
    req.done_slot  <= r.done_slot;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Send in bursts of random length, with random gaps between them unless steady_feed is set
  task automatic paced_send(job_req_t r);
    if (burst_left == 0) begin
      if (!steady_feed) pause_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(r);
  endtask

  initial begin
    job_req_t directed[$];
    sb          = new();
    burst_left  = 0;
    steady_feed = 1'b0;
    start_hold  = 1'b0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.opcode     = OP_CREATE;
    req.routine_id = '0;
    req.job_arg    = '0;
    req.done_slot  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: waiters, re-pointing, errors, a full table, then drain it
    directed.push_back(make_req(OP_CREATE, 16'h0000, 32'h0000_0000, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
    directed.push_back(make_req(OP_CREATE, 16'h0000, 32'h1234_5678, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h0000, 32'hA5A5_A5A5, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'hFFFF, 32'h5A5A_5A5A, 3'd0));
    directed.push_back(make_req(OP_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF, 3'd3));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd7));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd0));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd2));
    directed.push_back(make_req(OP_CREATE, 16'h1234, 32'h0BAD_F00D, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h8000, 32'h8000_0001, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h0001, 32'h0000_0001, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h0001, 32'h0000_0002, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h0001, 32'h0000_0003, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'h4321, 32'hFFFF_FFFF, 3'd0));
    directed.push_back(make_req(OP_CREATE, 16'hFFFF, 32'h7FFF_FFFF, 3'd0));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd1));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd3));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd5));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd6));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd7));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd0));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd2));
    directed.push_back(make_req(OP_COMPLETE, 16'h0000, 32'h0000_0000, 3'd4));
    directed.push_back(make_req(OP_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF, 3'd1));
    foreach (directed[i]) paced_send(directed[i]);

    // Random traffic with a long result hold-off and a full drain on the way
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) refresh_pool();
      if (n == 400) start_hold = 1'b1;
      steady_feed = (n >= 600 && n < 750);
      if (n == 800) begin
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
      end
      paced_send(random_request());
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
